FILE: rtl/smd_pkg.sv
package smd_pkg;

    // Delay store depth, a power of two so that address arithmetic wraps.
    localparam int DELAY_FRAMES = 2048;
    localparam int DELAY_AW     = $clog2(DELAY_FRAMES);

    // Sine quantization, a power of two.
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_AW      = $clog2(SINE_ENTRIES);

    localparam int PHASE_W = 32;
    localparam int SAMP_W  = 16;

    // Quarter-wave polynomial coefficients (Q15).
    localparam logic [15:0] POLY_C1 = 16'd2320;
    localparam logic [15:0] POLY_C2 = 16'd21024;
    localparam logic [15:0] POLY_C3 = 16'd51472;
    localparam logic [15:0] Q15_MAX = 16'd32767;

    // Shared multiplier operand and product widths.
    localparam int MUL_AW = 20;
    localparam int MUL_BW = 18;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Delay sum base*2^15 + depth*sine + rounding, signed.
    localparam int T_W = 39;

    // Configuration port.
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_BASE_DELAY = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MOD_DEPTH  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LFO_STEP   = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_GAIN       = 3'd3;

    localparam logic [18:0] RST_BASE_DELAY = 19'd67738;
    localparam logic [18:0] RST_MOD_DEPTH  = 19'd45158;
    localparam logic [31:0] RST_LFO_STEP   = 32'd24350;
    localparam logic [15:0] RST_GAIN       = 16'd256;

    typedef struct packed {
        logic signed [SAMP_W-1:0] left_in;
        logic signed [SAMP_W-1:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMP_W-1:0] left_out;
        logic signed [SAMP_W-1:0] right_out;
    } t_out_item;

    typedef struct packed {
        logic [18:0]  base_delay;
        logic [18:0]  mod_depth;
        logic [31:0]  lfo_step;
        logic [15:0]  gain;
    } t_cfg;

    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        logic [DELAY_AW-1:0] delay;
    } t_store_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_CUBE,
        S_POLY,
        S_LIN,
        S_SIN,
        S_DEP,
        S_DLY,
        S_RD,
        S_MIXL,
        S_MIXR,
        S_OUT
    } t_state;

endpackage

FILE: rtl/smd_cfg.sv
module smd_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [smd_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [smd_pkg::CFG_DW-1:0] i_cfg_data,
    output smd_pkg::t_cfg              o_cfg
);
    import smd_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_delay <= RST_BASE_DELAY;
            r_cfg.mod_depth  <= RST_MOD_DEPTH;
            r_cfg.lfo_step   <= RST_LFO_STEP;
            r_cfg.gain       <= RST_GAIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE_DELAY: r_cfg.base_delay <= i_cfg_data[18:0];
                CFG_MOD_DEPTH:  r_cfg.mod_depth  <= i_cfg_data[18:0];
                CFG_LFO_STEP:   r_cfg.lfo_step   <= i_cfg_data[31:0];
                CFG_GAIN:       r_cfg.gain       <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/smd_mult.sv
module smd_mult (
    input  logic                              i_clk,
    input  logic signed [smd_pkg::MUL_AW-1:0] i_a,
    input  logic signed [smd_pkg::MUL_BW-1:0] i_b,
    output logic signed [smd_pkg::MUL_PW-1:0] o_prod
);
    import smd_pkg::*;

    logic signed [MUL_PW-1:0] r_prod;

    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

endmodule

FILE: rtl/smd_store.sv
module smd_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smd_pkg::t_store_req i_req,
    input  smd_pkg::t_in_item   i_frame,
    output smd_pkg::t_in_item   o_wet
);
    import smd_pkg::*;

    logic [31:0]         r_mem [DELAY_FRAMES];
    logic [31:0]         r_q;
    logic                r_q_ok;
    logic [DELAY_AW-1:0] r_wi;
    logic                r_full;
    logic [DELAY_AW-1:0] w_rd_addr;

    // Slots beyond the write pointer have never been written before the first wrap.
    assign w_rd_addr = r_wi - i_req.delay;
    assign o_wet     = r_q_ok ? t_in_item'(r_q) : '0;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[r_wi] <= 32'(i_frame);
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi   <= '0;
            r_full <= 1'b0;
            r_q_ok <= 1'b0;
        end else if (i_req.rd_en) begin
            r_q_ok <= r_full || (w_rd_addr <= r_wi);
            r_wi   <= r_wi + 1'b1;
            if (r_wi == DELAY_AW'(DELAY_FRAMES - 1)) begin
                r_full <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.wr_en && i_req.rd_en))
        else $error("store written and read in one cycle");

    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("store full flag dropped");

    a_wi_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.rd_en |=> r_wi == $past(r_wi) + 1'b1)
        else $error("write pointer did not advance after read");
`endif

endmodule

FILE: rtl/stereo_modulated_delay_top.sv
// Stereo chorus / flanger. Each accepted frame is written into a 2048-frame
// circular delay store, a quarter-wave polynomial sine of the LFO phase sets
// the delay (base_delay + mod_depth * sine, 1/256 frame units, rounded and
// clamped), and the delayed frame is mixed half and half with the dry one,
// scaled by the Q8.8 gain and saturated. All arithmetic runs on one shared
// registered multiplier stepped by a sequencer (seven multiplies plus the
// store read), so a result is presented once its states are done and the
// output register is free; the input is stalled during that time and
// accepts the next frame in the cycle after the result is registered, so no
// frame is taken before the last is through. A result may wait in the output
// register while the next frame is already being worked on. The store reads
// as zero until it has been written, with no clearing pass after reset.
module stereo_modulated_delay_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  smd_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output smd_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [smd_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [smd_pkg::CFG_DW-1:0] i_cfg_data
);
    import smd_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    t_cfg                     w_cfg;
    logic [PHASE_W-1:0]       r_phase;
    t_in_item                 r_dry;
    logic [16:0]              r_x;
    logic                     r_neg;
    logic [15:0]              r_x2;
    logic signed [15:0]       r_sine;
    logic [DELAY_AW-1:0]      r_delay;
    logic signed [15:0]       r_yl;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_accept;
    logic                     w_emit;
    logic signed [MUL_AW-1:0] w_mul_a;
    logic signed [MUL_BW-1:0] w_mul_b;
    logic signed [MUL_PW-1:0] w_prod;
    t_store_req               w_req;
    t_in_item                 w_wet;

    logic [SINE_AW-1:0]       w_idx;
    logic [16:0]              w_p;
    logic [16:0]              w_x;
    logic [15:0]              w_q15;
    logic [15:0]              w_t1;
    logic [15:0]              w_t2;
    logic [15:0]              w_qsat;
    logic signed [T_W-1:0]    w_t;
    logic [DELAY_AW-1:0]      w_delay;
    logic signed [16:0]       w_m_l;
    logic signed [16:0]       w_m_r;
    logic signed [15:0]       w_y;

    // Halving with truncation toward zero.
    function automatic logic signed [16:0] half_tz(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return (e + $signed({16'b0, v[15]})) >>> 1;
    endfunction

    // Q8.8 gain product divided by 256 toward zero, then saturated.
    function automatic logic signed [15:0] gain_sat(input logic signed [MUL_PW-1:0] p);
        logic signed [MUL_PW-1:0] d;
        d = (p + (p[MUL_PW-1] ? MUL_PW'(255) : MUL_PW'(0))) >>> 8;
        if (d > MUL_PW'(32767)) begin
            return 16'sh7FFF;
        end else if (d < -MUL_PW'(32768)) begin
            return 16'sh8000;
        end else begin
            return d[15:0];
        end
    endfunction

    smd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    smd_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    smd_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_frame (i_in_data),
        .o_wet   (w_wet)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_emit      = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sine table position folded onto the quarter wave.
    assign w_idx = r_phase[PHASE_W-1 -: SINE_AW];
    assign w_p   = {w_idx, {(17 - SINE_AW){1'b0}}};
    assign w_x   = w_p[15] ? (17'd32768 - {2'b0, w_p[14:0]}) : {2'b0, w_p[14:0]};

    assign w_q15 = w_prod[30:15];
    assign w_t1  = POLY_C2 - w_q15;
    assign w_t2  = POLY_C3 - w_q15;
    assign w_qsat = (w_q15 > Q15_MAX) ? Q15_MAX : w_q15;

    assign w_t = $signed({5'b0, w_cfg.base_delay, 15'b0}) + $signed({w_prod[MUL_PW-1], w_prod})
               + T_W'(4194304);

    always_comb begin
        if (w_t <= 0) begin
            w_delay = '0;
        end else if ({1'b0, w_t[T_W-1:23]} > 17'(DELAY_FRAMES - 1)) begin
            w_delay = DELAY_AW'(DELAY_FRAMES - 1);
        end else begin
            w_delay = w_t[DELAY_AW+22:23];
        end
    end

    assign w_m_l = half_tz(r_dry.left_in) + half_tz(w_wet.left_in);
    assign w_m_r = half_tz(r_dry.right_in) + half_tz(w_wet.right_in);
    assign w_y   = gain_sat(w_prod);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_SQ;
            S_SQ:   n_state = S_CUBE;
            S_CUBE: n_state = S_POLY;
            S_POLY: n_state = S_LIN;
            S_LIN:  n_state = S_SIN;
            S_SIN:  n_state = S_DEP;
            S_DEP:  n_state = S_DLY;
            S_DLY:  n_state = S_RD;
            S_RD:   n_state = S_MIXL;
            S_MIXL: n_state = S_MIXR;
            S_MIXR: n_state = S_OUT;
            S_OUT:  if (w_emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_req     = '0;
        w_req.delay = r_delay;
        case (r_state)
            S_IDLE: w_req.wr_en = w_accept;
            S_SQ: begin
                w_mul_a = $signed({3'b0, r_x});
                w_mul_b = $signed({1'b0, r_x});
            end
            S_CUBE: begin
                w_mul_a = $signed({4'b0, w_q15});
                w_mul_b = $signed({2'b0, POLY_C1});
            end
            S_POLY: begin
                w_mul_a = $signed({4'b0, w_t1});
                w_mul_b = $signed({2'b0, r_x2});
            end
            S_LIN: begin
                w_mul_a = $signed({4'b0, w_t2});
                w_mul_b = $signed({1'b0, r_x});
            end
            S_DEP: begin
                w_mul_a = $signed({1'b0, w_cfg.mod_depth});
                w_mul_b = {{2{r_sine[15]}}, r_sine};
            end
            S_RD:   w_req.rd_en = 1'b1;
            S_MIXL: begin
                w_mul_a = {{3{w_m_l[16]}}, w_m_l};
                w_mul_b = $signed({2'b0, w_cfg.gain});
            end
            S_MIXR, S_OUT: begin
                w_mul_a = {{3{w_m_r[16]}}, w_m_r};
                w_mul_b = $signed({2'b0, w_cfg.gain});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_phase <= r_phase + w_cfg.lfo_step;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dry <= i_in_data;
            r_x   <= w_x;
            r_neg <= w_p[16];
        end
        if (r_state == S_CUBE) begin
            r_x2 <= w_q15;
        end
        if (r_state == S_SIN) begin
            r_sine <= r_neg ? -$signed(w_qsat) : $signed(w_qsat);
        end
        if (r_state == S_DLY) begin
            r_delay <= w_delay;
        end
        if (r_state == S_MIXR) begin
            r_yl <= w_y;
        end
        if (w_emit) begin
            r_out.left_out  <= r_yl;
            r_out.right_out <= w_y;
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after a transaction");

    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> o_out_valid && r_state == S_IDLE)
        else $error("result not presented after final step");

    a_hold_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && o_out_valid && i_out_stall) |=> r_state == S_OUT)
        else $error("sequencer left final step while output blocked");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SIN |=> (r_sine <= 16'sd32767 && r_sine >= -16'sd32767))
        else $error("sine out of Q15 range");
`endif

endmodule
